// ===== design/sysex_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the sysex 7-bit packing codec
// no dependencies; used by the front, queue, back and top level

package sysex_pkg;

	localparam int GROUP_LEN   = 7;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [6:0] LOW7_MASK = 7'h7F;
	localparam logic [6:0] HDR_MSB   = 7'h40;

	// command passed from front to back
	typedef enum logic [1:0] {
		CMD_STORE,
		CMD_FLUSH,
		CMD_EMIT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [2:0]  pos;
		logic [7:0]  data;
		logic        last;
	} cmd_t;

	// back-end sequencer states
	typedef enum logic {
		BK_IDLE,
		BK_FLUSH
	} back_state_t;

endpackage

// ===== design/sysex_front.sv =====
`timescale 1ns / 1ps
// front end: accepts message bytes, tracks group position, builds commands
// depends on sysex_pkg

module sysex_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr,
	input  logic               cfg_dir,
	input  logic               in_accept,
	input  logic [7:0]         in_byte,
	input  logic               in_last,
	output logic               push,
	output sysex_pkg::cmd_t    push_cmd
);

	logic       dir_q;
	logic [2:0] pos_q;
	logic [6:0] hdr_q;
	logic [2:0] pos_d;
	logic [6:0] hdr_d;
	logic       flush;
	logic       top_bit;

	// classify the byte and work out the next group position
	always_comb begin
		push     = 1'b0;
		push_cmd = '{kind: sysex_pkg::CMD_STORE, pos: pos_q, data: in_byte, last: in_last};
		pos_d    = pos_q;
		hdr_d    = hdr_q;
		flush    = 1'b0;
		top_bit  = hdr_q[3'(3'd7 - pos_q)];
		if (!dir_q) begin
			// pack: every byte goes to the back, the seventh or last one flushes
			flush = (pos_q == 3'(sysex_pkg::GROUP_LEN - 1)) || in_last;
			push  = in_accept;
			push_cmd.kind = flush ? sysex_pkg::CMD_FLUSH : sysex_pkg::CMD_STORE;
			pos_d = flush ? 3'd0 : 3'(pos_q + 3'd1);
		end else if (pos_q == 3'd0) begin
			// unpack header: kept here, nothing emitted
			hdr_d = in_byte[6:0];
			pos_d = in_last ? 3'd0 : 3'd1;
		end else begin
			// unpack data: restore top bit from the header
			push          = in_accept;
			push_cmd.kind = sysex_pkg::CMD_EMIT;
			push_cmd.data = {top_bit, in_byte[6:0]};
			pos_d         = (pos_q == 3'(sysex_pkg::GROUP_LEN) || in_last) ? 3'd0
				: 3'(pos_q + 3'd1);
		end
	end

	// direction, position and header registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= 1'b0;
			pos_q <= 3'd0;
			hdr_q <= 7'd0;
		end else if (cfg_wr) begin
			dir_q <= cfg_dir;
			pos_q <= 3'd0;
			hdr_q <= 7'd0;
		end else if (in_accept) begin
			pos_q <= pos_d;
			hdr_q <= hdr_d;
		end
	end

	// pack groups never reach stored position 7
	a_pack_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!dir_q |-> pos_q != 3'd7)
		else $error("pack position out of range");
	// a flush always resets the position
	a_flush_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && !dir_q && flush && !cfg_wr) |=> pos_q == 3'd0)
		else $error("position not cleared after flush");
	// unpack header never produces a command
	a_hdr_nopush: assert property (@(posedge clk) disable iff (!arst_n)
		(dir_q && pos_q == 3'd0) |-> !push)
		else $error("header byte pushed a command");

endmodule

// ===== design/sysex_cmd_fifo.sv =====
`timescale 1ns / 1ps
// short command queue between front and back end
// depends on sysex_pkg

module sysex_cmd_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sysex_pkg::cmd_t    push_cmd,
	output logic               full,
	input  logic               pop,
	output sysex_pkg::cmd_t    pop_cmd,
	output logic               not_empty
);

	localparam int PTR_W = $clog2(sysex_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(sysex_pkg::QUEUE_DEPTH + 1);

	sysex_pkg::cmd_t  entry_q [sysex_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(sysex_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_cmd   = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(sysex_pkg::QUEUE_DEPTH - 1)) ? '0
					: PTR_W'(wr_ptr_q + 1'b1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(sysex_pkg::QUEUE_DEPTH - 1)) ? '0
					: PTR_W'(rd_ptr_q + 1'b1);
			if (push && !pop)
				count_q <= CNT_W'(count_q + 1'b1);
			else if (pop && !push)
				count_q <= CNT_W'(count_q - 1'b1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("command queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !not_empty))
		else $error("command queue underflow");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(sysex_pkg::QUEUE_DEPTH))
		else $error("command queue count out of range");

endmodule

// ===== design/sysex_back.sv =====
`timescale 1ns / 1ps
// back end: group store, pack header, flush sequencer and output register
// depends on sysex_pkg

module sysex_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr,
	input  logic               q_valid,
	input  sysex_pkg::cmd_t    q_cmd,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,
	output logic               m_tlast
);

	sysex_pkg::back_state_t state_q, state_d;
	logic [6:0] store_q [sysex_pkg::GROUP_LEN];
	logic [6:0] hdr_q;
	logic [6:0] flush_hdr_q;
	logic [2:0] flush_len_q;
	logic       flush_last_q;
	logic [2:0] cnt_q, cnt_d;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       out_free;
	logic       load;
	logic [7:0] load_byte;
	logic       load_last;
	logic [2:0] idx;
	logic [6:0] hdr_mask;

	assign out_free = !out_valid_q || m_tready;
	assign idx      = 3'(cnt_q - 3'd1);
	assign hdr_mask = (sysex_pkg::HDR_MSB >> q_cmd.pos) & {7{q_cmd.data[7]}};

	// next state and outputs of the sequencer
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		pop       = 1'b0;
		load      = 1'b0;
		load_byte = 8'd0;
		load_last = 1'b0;
		case (state_q)
			sysex_pkg::BK_IDLE: begin
				if (q_valid) begin
					case (q_cmd.kind)
						sysex_pkg::CMD_STORE: begin
							pop = 1'b1;
						end
						sysex_pkg::CMD_FLUSH: begin
							pop     = 1'b1;
							state_d = sysex_pkg::BK_FLUSH;
							cnt_d   = 3'd0;
						end
						sysex_pkg::CMD_EMIT: begin
							if (out_free) begin
								pop       = 1'b1;
								load      = 1'b1;
								load_byte = q_cmd.data;
								load_last = q_cmd.last;
							end
						end
						default: begin
							pop = 1'b1;
						end
					endcase
				end
			end
			sysex_pkg::BK_FLUSH: begin
				if (out_free) begin
					load  = 1'b1;
					cnt_d = 3'(cnt_q + 3'd1);
					if (cnt_q == 3'd0) begin
						load_byte = {1'b0, flush_hdr_q};
					end else begin
						load_byte = {1'b0, store_q[idx]};
						load_last = flush_last_q && (idx == flush_len_q);
						if (idx == flush_len_q)
							state_d = sysex_pkg::BK_IDLE;
					end
				end
			end
			default: begin
				state_d = sysex_pkg::BK_IDLE;
			end
		endcase
	end

	// group store, flush header, length and last flag, output byte and last; no reset needed
	always_ff @(posedge clk) begin
		if (pop && q_cmd.kind != sysex_pkg::CMD_EMIT)
			store_q[q_cmd.pos] <= q_cmd.data[6:0] & sysex_pkg::LOW7_MASK;
		if (pop && q_cmd.kind == sysex_pkg::CMD_FLUSH) begin
			flush_hdr_q  <= hdr_q | hdr_mask;
			flush_len_q  <= q_cmd.pos;
			flush_last_q <= q_cmd.last;
		end
		if (load) begin
			out_byte_q <= load_byte;
			out_last_q <= load_last;
		end
	end

	// sequencer, pack header and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sysex_pkg::BK_IDLE;
			cnt_q       <= 3'd0;
			hdr_q       <= 7'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cfg_wr)
				hdr_q <= 7'd0;
			else if (pop && q_cmd.kind == sysex_pkg::CMD_STORE)
				hdr_q <= hdr_q | hdr_mask;
			else if (pop && q_cmd.kind == sysex_pkg::CMD_FLUSH)
				hdr_q <= 7'd0;
			if (load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;

	// nothing is popped while a flush is running
	a_flush_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sysex_pkg::BK_FLUSH |-> !pop)
		else $error("queue popped during flush");
	// packed bytes are 7-bit safe
	a_pack_7bit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sysex_pkg::BK_FLUSH && load) |-> !load_byte[7])
		else $error("packed byte has top bit set");
	// flush counter stays within the group
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sysex_pkg::BK_FLUSH |-> cnt_q <= 3'(flush_len_q + 3'd1))
		else $error("flush counter past group end");

endmodule

// ===== design/sysex_eight_to_seven_bit_codec.sv =====
`timescale 1ns / 1ps
// top level of the sysex 7-bit packing codec
// depends on sysex_pkg, sysex_front, sysex_cmd_fifo, sysex_back
//
// usage
// - s_* carries message bytes (tdata = data_byte, tlast = end of message),
//   m_* carries converted bytes (tdata = out_byte, tlast = end of message).
// - cfg_* writes the direction: 0 packs 8-bit bytes into 7-bit groups,
//   1 unpacks them; every write drops any partial group. write only when idle.
// - the front end takes one byte per cycle while the two-entry command queue
//   has room; the back end drives one output byte per cycle into the output
//   register whenever the register is free.
// - unpack: one byte out per data byte, passed through the command queue and
//   the output register to m_tvalid; header bytes produce nothing.
// - pack: a group of n bytes (n = 1..7) gives n+1 output bytes once the
//   seventh or last byte is in; the back end pops the command of each byte,
//   then emits the header and the group's bytes without taking commands.
// - reset clears direction to pack, positions, headers, queue and m_tvalid.
// - when m_tready is low the output register holds, the back end stops at the
//   next byte to emit, the queue fills and s_tready drops; no transaction is
//   lost.

module sysex_eight_to_seven_bit_codec (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,    // [7:0] data_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,    // [7:0] out_byte
	output logic       m_tlast
);

	logic            cfg_wr;
	logic            in_accept;
	logic            push;
	sysex_pkg::cmd_t push_cmd;
	logic            q_full;
	logic            pop;
	sysex_pkg::cmd_t pop_cmd;
	logic            q_valid;

	// handshakes
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid;
	assign s_tready  = !q_full;
	assign in_accept = s_tvalid && s_tready;

	sysex_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.cfg_dir   (cfg_data),
		.in_accept (in_accept),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	sysex_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (pop),
		.pop_cmd   (pop_cmd),
		.not_empty (q_valid)
	);

	sysex_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_wr),
		.q_valid  (q_valid),
		.q_cmd    (pop_cmd),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// self-checking bench for the sysex 7-bit packing codec: directed and random messages
// in both directions, checked transaction by transaction against a behavioural predictor
// depends on sysex_pkg and sysex_eight_to_seven_bit_codec

module testbench;

	localparam bit DIR_PACK   = 1'b0;
	localparam bit DIR_UNPACK = 1'b1;
	localparam int SETTLE_CYCLES = 16;

	// ready patterns for the output side
	typedef enum logic [1:0] {
		RDY_ALWAYS,
		RDY_RANDOM,
		RDY_SPARSE
	} ready_mode_t;

	typedef struct packed {
		logic [7:0] value;
		logic       fin;
	} msg_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_data = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;    // [7:0] data_byte
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;            // [7:0] out_byte
	logic       m_tlast;

	msg_byte_t   pending_bytes[$];
	msg_byte_t   expected_out[$];
	int          fail_count = 0;

	// predictor state
	logic        mode_unpack = DIR_PACK;
	logic [6:0]  grp_low[sysex_pkg::GROUP_LEN];
	logic [6:0]  hdr_bits = '0;
	int          grp_pos = 0;

	// sender burst shaping
	int          burst_left = 0;
	int          gap_left = 0;

	// receiver stall pattern
	ready_mode_t rdy_mode = RDY_ALWAYS;
	int          rdy_count = 0;

	sysex_eight_to_seven_bit_codec dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input int exp_val, input int got_val);
		$display("%0t ns: mismatch on %s, expected 0x%02h, got 0x%02h",
			$time, what, exp_val, got_val);
		fail_count++;
	endtask

	// work out the output bytes one input byte causes
	task automatic predict_codec_output(input logic [7:0] b, input logic fin);
		int pos;
		msg_byte_t res;
		pos = grp_pos;
		if (mode_unpack == DIR_PACK) begin
			if (pos >= sysex_pkg::GROUP_LEN)
				pos = 0;
			grp_low[pos] = b[6:0];
			if (b[7])
				hdr_bits[6 - pos] = 1'b1;
			pos++;
			if (pos == sysex_pkg::GROUP_LEN || fin) begin
				res.value = {1'b0, hdr_bits};
				res.fin = 1'b0;
				expected_out.push_back(res);
				for (int i = 0; i < pos; i++) begin
					res.value = {1'b0, grp_low[i]};
					res.fin = fin && (i + 1 == pos);
					expected_out.push_back(res);
				end
				hdr_bits = '0;
				pos = 0;
			end
		end else if (pos == 0) begin
			// header byte: top bit dropped, nothing emitted
			hdr_bits = b[6:0];
			pos = fin ? 0 : 1;
		end else begin
			// data byte gets its top bit back from the header
			res.value = {hdr_bits[sysex_pkg::GROUP_LEN - pos], b[6:0]};
			res.fin = fin;
			expected_out.push_back(res);
			pos++;
			if (pos > sysex_pkg::GROUP_LEN || fin)
				pos = 0;
		end
		grp_pos = pos;
	endtask

	task automatic push_byte(input logic [7:0] value, input logic fin);
		msg_byte_t item;
		item.value = value;
		item.fin = fin;
		pending_bytes.push_back(item);
	endtask

	// wait for the block to drain, then give it time to finish any buffered work
	task automatic settle();
		while (pending_bytes.size() != 0 || s_tvalid || expected_out.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_direction(input logic dir);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= dir;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// mostly whole messages with random content, some noise and cut-off messages
	task automatic queue_random_phase(input logic dir, input int n_items);
		int count;
		int len;
		bit cut;
		count = 0;
		while (count < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				count++;
			end else begin
				if ($urandom_range(0, 5) == 0)
					len = $urandom_range(1, 24);
				else
					len = $urandom_range(1, 9);
				if (dir == DIR_UNPACK && len % 8 == 1 && $urandom_range(0, 3) != 0)
					len++;
				cut = ($urandom_range(0, 7) == 0);
				for (int i = 0; i < len; i++)
					push_byte(8'($urandom_range(0, 255)), (i == len - 1) && !cut);
				count += len;
			end
		end
	endtask

	// input side: bursts of random length separated by random gaps
	always @(posedge clk) begin : drive_input
		msg_byte_t item;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_bytes.size() != 0) begin
				item = pending_bytes.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= item.value;
				s_tlast <= item.fin;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 30);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// output side: stall pattern, chosen at random each time rdy_count wraps to zero
	always @(posedge clk) begin
		if (rdy_count == 0)
			rdy_mode <= ready_mode_t'($urandom_range(0, 2));
		rdy_count <= (rdy_count + 1) % 48;
		case (rdy_mode)
			RDY_ALWAYS: m_tready <= arst_n;
			RDY_RANDOM: m_tready <= arst_n && $urandom_range(0, 1);
			default:    m_tready <= arst_n && (rdy_count % 4 == 0);
		endcase
	end

	// monitor: predict on accepted input, check each output transaction
	always @(posedge clk) begin : monitor
		msg_byte_t exp_item;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				mode_unpack = cfg_data;
				hdr_bits = '0;
				grp_pos = 0;
			end
			if (s_tvalid && s_tready)
				predict_codec_output(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (expected_out.size() == 0) begin
					report_mismatch("unexpected output byte", 0, int'(m_tdata));
				end else begin
					exp_item = expected_out.pop_front();
					if (m_tdata !== exp_item.value)
						report_mismatch("out_byte", int'(exp_item.value), int'(m_tdata));
					if (m_tlast !== exp_item.fin)
						report_mismatch("out_last", int'(exp_item.fin), int'(m_tlast));
				end
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// pack: single-byte messages at both extremes
		write_direction(DIR_PACK);
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b1);
		// full group with no last, then a short message
		push_byte(8'h80, 1'b0);
		push_byte(8'h7F, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h81, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(8'hC0, 1'b0);
		push_byte(8'hAA, 1'b0);
		push_byte(8'h55, 1'b1);
		// partial group, dropped by the next direction write
		push_byte(8'hF0, 1'b0);
		push_byte(8'h0F, 1'b0);
		settle();

		// unpack: header marked last emits nothing
		write_direction(DIR_UNPACK);
		push_byte(8'hFF, 1'b1);
		// header with top bit set, then a full group of data with mixed top bits
		push_byte(8'hD5, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h7F, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h2A, 1'b0);
		push_byte(8'hD5, 1'b0);
		push_byte(8'h01, 1'b0);
		// short group ending the message
		push_byte(8'h2A, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h7F, 1'b1);
		settle();

		// random phases through both directions, repeating a direction too
		write_direction(DIR_PACK);
		queue_random_phase(DIR_PACK, 12);
		settle();
		write_direction(DIR_UNPACK);
		queue_random_phase(DIR_UNPACK, 12);
		settle();
		write_direction(DIR_UNPACK);
		queue_random_phase(DIR_UNPACK, 12);
		settle();
		write_direction(DIR_PACK);
		queue_random_phase(DIR_PACK, 12);
		settle();
		write_direction(DIR_PACK);
		queue_random_phase(DIR_PACK, 12);
		settle();
		write_direction(DIR_UNPACK);
		queue_random_phase(DIR_UNPACK, 12);
		settle();

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// watchdog against a hung handshake
	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
